// ===== src/stable_sorted_priority_queue_top_assert.svh =====
// Assertion macros shared by the priority queue RTL.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define SSPQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define SSPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SSPQ_ASSERT_IMPL(label, ante, cons, msg)
`define SSPQ_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== src/sspq_pkg.sv =====
// Package with the types and constants of the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none
package sspq_pkg;

    localparam int KIND_W   = 2;
    localparam int TAG_W    = 32;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 5;

    // Request operation codes.
    typedef enum logic [KIND_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        CS_IDLE = 2'd0,
        CS_CMP  = 2'd1,
        CS_UPD  = 2'd2
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic compare;
        logic commit;
    } pq_cmd_t;

endpackage
`default_nettype wire

// ===== src/sspq_req_if.sv =====
// Request channel interface of the priority queue.
`timescale 1ns / 1ps
`default_nettype none
interface sspq_req_if
    import sspq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] priority_req;

    modport source (output valid, output kind, output tag, output priority_req, input ready);
    modport sink   (input valid, input kind, input tag, input priority_req, output ready);
endinterface
`default_nettype wire

// ===== src/sspq_rsp_if.sv =====
// Result channel interface of the priority queue.
`timescale 1ns / 1ps
`default_nettype none
interface sspq_rsp_if
    import sspq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    out_tag;
    logic [PRIO_W-1:0]   out_priority;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    count;

    modport source (output valid, output status, output out_tag, output out_priority,
                    output position, output count, input ready);
    modport sink   (input valid, input status, input out_tag, input out_priority,
                    input position, input count, output ready);
endinterface
`default_nettype wire

// ===== src/stable_sorted_priority_queue_top.sv =====
// Top level of the stable sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none
// A bounded priority queue of up to CAPACITY entries held in a row of cells in descending
// priority order; entries of equal priority leave in the order they arrived. Each request
// transaction (insert, remove head, find by tag) yields exactly one result transaction that
// carries a status, the removed tag, the removed or found priority, the 1-based position of
// a found entry and the entry count after the operation. A request passes a compare state,
// in which every cell compares its priority and tag with the request in parallel, and then
// an update state, in which the cell row shifts and the result register is loaded and
// offered. No request is taken in the compare state; the next one is taken as the update
// commits. A result that is held back stalls the queue only once a further result is ready
// to be written. Tags wider than TAG_BITS and priorities wider than PRIORITY_BITS keep their
// low bits. Entries are not cleared at reset; only the count is, so the block is ready
// straight after reset.
module stable_sorted_priority_queue_top
    import sspq_pkg::*;
#(
    parameter int CAPACITY      = 16,
    parameter int TAG_BITS      = 32,
    parameter int PRIORITY_BITS = 8
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sspq_req_if.sink   req,
    sspq_rsp_if.source rsp
);

    pq_cmd_t cmd;

    // The controller owns the handshakes and sequencing.
    sspq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    // The datapath holds the entries, the compare vectors and the result register.
    sspq_datapath #(
        .CAPACITY      (CAPACITY),
        .TAG_BITS      (TAG_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .kind         (req.kind),
        .tag          (req.tag),
        .priority_req (req.priority_req),
        .status       (rsp.status),
        .out_tag      (rsp.out_tag),
        .out_priority (rsp.out_priority),
        .position     (rsp.position),
        .count        (rsp.count)
    );

endmodule
`default_nettype wire

// ===== src/sspq_ctrl.sv =====
// Controller state machine of the priority queue.
`timescale 1ns / 1ps
`default_nettype none
`include "stable_sorted_priority_queue_top_assert.svh"
module sspq_ctrl
    import sspq_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    output logic         req_ready,
    output logic         rsp_valid,
    input  wire logic    rsp_ready,
    output pq_cmd_t      cmd
);

    ctl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       commit;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= CS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        commit      = 1'b0;
        req_ready   = 1'b0;
        unique case (state_reg)
            CS_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid) begin
                    state_next = CS_CMP;
                end
            end
            CS_CMP:
            begin
                state_next = CS_UPD;
            end
            CS_UPD:
            begin
                // The result register must be free or emptying this cycle.
                commit    = !out_valid_reg || rsp_ready;
                req_ready = commit;
                if (commit) begin
                    state_next = req_valid ? CS_CMP : CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase

        if (commit) begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end

        cmd.load    = req_valid && req_ready;
        cmd.compare = (state_reg == CS_CMP);
        cmd.commit  = commit;
    end

    assign rsp_valid = out_valid_reg;

    `SSPQ_ASSERT_IMPL(a_no_accept_in_cmp, state_reg == CS_CMP, !req_ready, "request accepted during compare")
    `SSPQ_ASSERT_NEXT(a_cmp_then_upd, state_reg == CS_CMP, state_reg == CS_UPD, "compare not followed by update")
    `SSPQ_ASSERT_NEXT(a_commit_shows, cmd.commit, out_valid_reg, "committed result not presented")

endmodule
`default_nettype wire

// ===== src/sspq_datapath.sv =====
// Datapath of the priority queue: request latch, cell row, compare vectors and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "stable_sorted_priority_queue_top_assert.svh"
module sspq_datapath
    import sspq_pkg::*;
#(
    parameter int CAPACITY      = 16,
    parameter int TAG_BITS      = 32,
    parameter int PRIORITY_BITS = 8
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pq_cmd_t             cmd,
    input  wire logic [KIND_W-1:0]   kind,
    input  wire logic [TAG_W-1:0]    tag,
    input  wire logic [PRIO_W-1:0]   priority_req,
    output logic [STATUS_W-1:0]      status,
    output logic [TAG_W-1:0]         out_tag,
    output logic [PRIO_W-1:0]        out_priority,
    output logic [POS_W-1:0]         position,
    output logic [POS_W-1:0]         count
);

    localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int PW = (PRIORITY_BITS < PRIO_W) ? PRIORITY_BITS : PRIO_W;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [KIND_W-1:0]   kind_reg;
    logic [TW-1:0]       tag_reg;
    logic [PW-1:0]       prio_reg;

    logic [TW-1:0]       cell_tag_reg  [CAPACITY];
    logic [PW-1:0]       cell_prio_reg [CAPACITY];
    logic [CW-1:0]       count_reg, count_next;

    logic [CAPACITY-1:0] ge_reg, ge_next, match_reg, match_next;
    logic [CAPACITY-1:0] first, take, shift;
    logic                hit, full, empty, ins_ok, rem_ok;
    logic [CW-1:0]       hit_pos;
    logic [PW-1:0]       hit_prio;

    logic [STATUS_W-1:0] status_reg, status_next;
    logic [TAG_W-1:0]    out_tag_reg, out_tag_next;
    logic [PRIO_W-1:0]   out_prio_reg, out_prio_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    out_count_reg;

    // Request latch.
    always_ff @(posedge clk) begin
        if (cmd.load) begin
            kind_reg <= kind;
            tag_reg  <= tag[TW-1:0];
            prio_reg <= priority_req[PW-1:0];
        end
    end

    // Per-cell compare against the latched request; cells beyond the count never match.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            ge_next[i]    = (CW'(i) < count_reg) && (cell_prio_reg[i] >= prio_reg);
            match_next[i] = (CW'(i) < count_reg) && (cell_tag_reg[i] == tag_reg);
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.compare) begin
            ge_reg    <= ge_next;
            match_reg <= match_next;
        end
    end

    assign full   = (count_reg == CAP_C);
    assign empty  = (count_reg == '0);
    assign ins_ok = cmd.commit && (kind_reg == OP_INSERT) && !full;
    assign rem_ok = cmd.commit && (kind_reg == OP_REMOVE) && !empty;

    // Lowest matching cell is isolated by ANDing the match vector with its two's complement.
    always_comb begin
        first    = match_reg & ((~match_reg) + CAPACITY'(1));
        hit      = |match_reg;
        hit_pos  = '0;
        hit_prio = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (first[i]) begin
                hit_pos  = hit_pos | CW'(i + 1);
                hit_prio = hit_prio | cell_prio_reg[i];
            end
        end
    end

    // Cell row: shifts down for an insert, up for a remove.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic [TW-1:0] dn_tag, up_tag;
        logic [PW-1:0] dn_prio, up_prio;

        if (gi == 0) begin : g_head
            assign take[gi]  = !ge_reg[gi];
            assign shift[gi] = 1'b0;
            assign dn_tag    = cell_tag_reg[gi];
            assign dn_prio   = cell_prio_reg[gi];
        end
        else begin : g_body
            assign take[gi]  = !ge_reg[gi] && ge_reg[gi-1];
            assign shift[gi] = !ge_reg[gi] && !ge_reg[gi-1];
            assign dn_tag    = cell_tag_reg[gi-1];
            assign dn_prio   = cell_prio_reg[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_tail
            assign up_tag  = cell_tag_reg[gi];
            assign up_prio = cell_prio_reg[gi];
        end
        else begin : g_inner
            assign up_tag  = cell_tag_reg[gi+1];
            assign up_prio = cell_prio_reg[gi+1];
        end

        always_ff @(posedge clk) begin
            if (ins_ok) begin
                if (take[gi]) begin
                    cell_tag_reg[gi]  <= tag_reg;
                    cell_prio_reg[gi] <= prio_reg;
                end
                else if (shift[gi]) begin
                    cell_tag_reg[gi]  <= dn_tag;
                    cell_prio_reg[gi] <= dn_prio;
                end
            end
            else if (rem_ok) begin
                cell_tag_reg[gi]  <= up_tag;
                cell_prio_reg[gi] <= up_prio;
            end
        end
    end

    // Result and new count.
    always_comb begin
        status_next   = ST_OK;
        out_tag_next  = '0;
        out_prio_next = '0;
        pos_next      = '0;
        count_next    = count_reg;
        unique case (kind_reg)
            OP_INSERT:
            begin
                if (full) begin
                    status_next = ST_FULL;
                end
                else begin
                    count_next = count_reg + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end
                else begin
                    out_tag_next  = TAG_W'(cell_tag_reg[0]);
                    out_prio_next = PRIO_W'(cell_prio_reg[0]);
                    count_next    = count_reg - 1'b1;
                end
            end
            OP_FIND:
            begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end
                else if (hit) begin
                    out_prio_next = PRIO_W'(hit_prio);
                    pos_next      = POS_W'(hit_pos);
                end
                else begin
                    status_next = ST_NOTFOUND;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            count_reg <= '0;
        end
        else if (cmd.commit) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.commit) begin
            status_reg    <= status_next;
            out_tag_reg   <= out_tag_next;
            out_prio_reg  <= out_prio_next;
            pos_reg       <= pos_next;
            out_count_reg <= POS_W'(count_next);
        end
    end

    assign status       = status_reg;
    assign out_tag      = out_tag_reg;
    assign out_priority = out_prio_reg;
    assign position     = pos_reg;
    assign count        = out_count_reg;

    `SSPQ_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CAP_C, "entry count above capacity")
    `SSPQ_ASSERT_IMPL(a_first_onehot, cmd.commit, $onehot0(first), "more than one first match")
    `SSPQ_ASSERT_IMPL(a_sorted_prefix, cmd.commit, ((ge_reg + CAPACITY'(1)) & ge_reg) == '0, "cell row out of order")
    `SSPQ_ASSERT_NEXT(a_insert_grows, ins_ok, count_reg == $past(count_reg) + 1'b1, "insert did not add an entry")

endmodule
`default_nettype wire
